[rtl/iss_pkg.sv]
`default_nettype none
package iss_pkg;

   localparam int PIXEL_COUNT_BITS = 24;

   // accumulator widths follow from the pixel count bound
   localparam int CNT_W  = PIXEL_COUNT_BITS + 1;
   localparam int SUM_W  = PIXEL_COUNT_BITS + 8;
   localparam int SQ_W   = PIXEL_COUNT_BITS + 16;
   localparam int DW     = CNT_W + SQ_W;        // N*Q - S^2
   localparam int DIV_W  = DW + 16;             // (D << 16) dividend
   localparam int ITER_W = $clog2(DIV_W + 1);

   localparam int ROOT_W     = 32;
   localparam int ROOT_STEPS = ROOT_W / 2;
   localparam int Y_W        = 30;              // 65536*D/N^2 stays below 2^30

   localparam logic [7:0] DARK_LIMIT_RESET   = 8'd85;
   localparam logic [7:0] MEDIUM_LIMIT_RESET = 8'd170;
   localparam logic [7:0] PIXEL_MAX          = 8'd255;

   typedef enum logic {
      REG_DARK_LIMIT   = 1'b0,
      REG_MEDIUM_LIMIT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [24:0] pixel_count;
      logic [7:0]  min_value;
      logic [7:0]  max_value;
      logic [15:0] mean_q8;
      logic [21:0] variance_q8;
      logic [14:0] std_dev_q8;
      logic [24:0] dark_total;
      logic [24:0] medium_total;
      logic [24:0] bright_total;
      logic        overflow;
   } rsp_type;

   typedef struct packed {
      logic [7:0] dark_limit;
      logic [7:0] medium_limit;
   } cfg_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [7:0]       min_value;
      logic [7:0]       max_value;
      logic [SUM_W-1:0] sum;
      logic [SQ_W-1:0]  square_sum;
      logic [CNT_W-1:0] dark;
      logic [CNT_W-1:0] medium_cnt;
      logic [CNT_W-1:0] bright;
      logic             overflow;
   } stats_type;

   typedef struct packed {
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      logic          subtract;
   } alu_op_type;

   typedef enum logic [2:0] {
      FIN_IDLE,
      FIN_MUL_NQ,
      FIN_MUL_SS,
      FIN_DIV_MEAN,
      FIN_DIV_A,
      FIN_DIV_Y,
      FIN_SQRT,
      FIN_DONE
   } fin_state_type;

endpackage
`default_nettype wire

[rtl/iss_addsub.sv]
`default_nettype none
module iss_addsub import iss_pkg::*; (
   input  alu_op_type    op,
   output logic [DW:0]   y
);

   // top bit of y is the carry, or the borrow on subtract
   always_comb begin
      if (op.subtract) begin
         y = {1'b0, op.a} - {1'b0, op.b};
      end else begin
         y = {1'b0, op.a} + {1'b0, op.b};
      end
   end

endmodule
`default_nettype wire

[rtl/iss_csr.sv]
`default_nettype none
module iss_csr import iss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [7:0]  dark_ff, dark_in;
   logic [7:0]  medium_ff, medium_in;
   csr_reg_type sel;
   logic        wr;

   assign sel    = csr_reg_type'(paddr[2]);
   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite && pready;

   always_comb begin
      dark_in   = dark_ff;
      medium_in = medium_ff;
      if (wr) begin
         case (sel)
            REG_DARK_LIMIT:   dark_in   = pwdata[7:0];
            REG_MEDIUM_LIMIT: medium_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dark_ff   <= DARK_LIMIT_RESET;
         medium_ff <= MEDIUM_LIMIT_RESET;
      end else begin
         dark_ff   <= dark_in;
         medium_ff <= medium_in;
      end
   end

   always_comb begin
      case (sel)
         REG_DARK_LIMIT:   prdata = {24'd0, dark_ff};
         REG_MEDIUM_LIMIT: prdata = {24'd0, medium_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.dark_limit   = dark_ff;
   assign cfg.medium_limit = medium_ff;

endmodule
`default_nettype wire

[rtl/iss_accum.sv]
`default_nettype none
module iss_accum import iss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req,
   input  cfg_type   cfg,
   output stats_type stats
);

   localparam stats_type STATS_CLEAR = '{
      count:      '0,
      min_value:  PIXEL_MAX,
      max_value:  8'd0,
      sum:        '0,
      square_sum: '0,
      dark:       '0,
      medium_cnt: '0,
      bright:     '0,
      overflow:   1'b0
   };

   stats_type   acc_ff, acc_in, upd;
   logic [15:0] px_sq;

   assign px_sq = {8'd0, req.pixel} * {8'd0, req.pixel};

   always_comb begin
      upd = acc_ff;
      if (accept) begin
         // top count bit set means the bound is reached
         if (!acc_ff.count[CNT_W-1]) begin
            upd.count      = acc_ff.count + CNT_W'(1);
            upd.sum        = acc_ff.sum + SUM_W'(req.pixel);
            upd.square_sum = acc_ff.square_sum + SQ_W'(px_sq);
            if (req.pixel < acc_ff.min_value) upd.min_value = req.pixel;
            if (req.pixel > acc_ff.max_value) upd.max_value = req.pixel;
            if (req.pixel <= cfg.dark_limit) begin
               upd.dark = acc_ff.dark + CNT_W'(1);
            end else if (req.pixel <= cfg.medium_limit) begin
               upd.medium_cnt = acc_ff.medium_cnt + CNT_W'(1);
            end else begin
               upd.bright = acc_ff.bright + CNT_W'(1);
            end
         end else begin
            upd.overflow = 1'b1;
         end
      end
      acc_in = (accept && req.last) ? STATS_CLEAR : upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= STATS_CLEAR;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // frame totals including the pixel of this beat
   assign stats = upd;

endmodule
`default_nettype wire

[rtl/iss_finish.sv]
`default_nettype none
module iss_finish import iss_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  stats_type stats,
   input  logic      out_free,
   output logic      busy,
   output logic      done,
   output rsp_type   rsp
);

   localparam logic [ITER_W-1:0] ITER_ONE = ITER_W'(1);

   fin_state_type     state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [DW-1:0]     acc_ff, acc_in;
   logic [DW-1:0]     opnd_ff, opnd_in;
   logic [SUM_W-1:0]  mult_ff, mult_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [SUM_W-1:0]  s_ff, s_in;
   rsp_type           rsp_ff, rsp_in;

   alu_op_type        op;
   logic [DW:0]       alu_y;
   logic              borrow;
   logic [DW-1:0]     shifted;

   iss_addsub u_addsub (
      .op (op),
      .y  (alu_y)
   );

   assign borrow  = alu_y[DW];
   assign shifted = {rem_ff[DW-2:0], quo_ff[DIV_W-1]};

   always_comb begin
      op.a        = acc_ff;
      op.b        = opnd_ff;
      op.subtract = 1'b0;
      case (state_ff)
         FIN_MUL_NQ: begin
            op.subtract = 1'b0;
         end
         FIN_MUL_SS: begin
            op.subtract = 1'b1;
         end
         FIN_DIV_MEAN, FIN_DIV_A, FIN_DIV_Y: begin
            op.a        = shifted;
            op.b        = DW'(n_ff);
            op.subtract = 1'b1;
         end
         FIN_SQRT: begin
            // root and bit never overlap, so OR is the sum
            op.b        = DW'(root_ff | bit_ff);
            op.subtract = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      acc_in   = acc_ff;
      opnd_in  = opnd_ff;
      mult_in  = mult_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      n_in     = n_ff;
      s_in     = s_ff;
      rsp_in   = rsp_ff;
      done     = 1'b0;
      case (state_ff)
         FIN_IDLE: begin
            if (start) begin
               n_in                = stats.count;
               s_in                = stats.sum;
               rsp_in.pixel_count  = 25'(stats.count);
               rsp_in.min_value    = stats.min_value;
               rsp_in.max_value    = stats.max_value;
               rsp_in.mean_q8      = '0;
               rsp_in.variance_q8  = '0;
               rsp_in.std_dev_q8   = '0;
               rsp_in.dark_total   = 25'(stats.dark);
               rsp_in.medium_total = 25'(stats.medium_cnt);
               rsp_in.bright_total = 25'(stats.bright);
               rsp_in.overflow     = stats.overflow;
               acc_in              = '0;
               opnd_in             = DW'(stats.square_sum);
               mult_in             = SUM_W'(stats.count);
               iter_in             = ITER_W'(CNT_W);
               if (stats.count == '0) begin
                  state_in = FIN_DONE;
               end else begin
                  state_in = FIN_MUL_NQ;
               end
            end
         end
         FIN_MUL_NQ, FIN_MUL_SS: begin
            // shift-add multiply, multiplier LSB first
            if (mult_ff[0]) acc_in = alu_y[DW-1:0];
            opnd_in = {opnd_ff[DW-2:0], 1'b0};
            mult_in = {1'b0, mult_ff[SUM_W-1:1]};
            iter_in = iter_ff - ITER_ONE;
            if (iter_ff == ITER_ONE) begin
               if (state_ff == FIN_MUL_NQ) begin
                  state_in = FIN_MUL_SS;
                  opnd_in  = DW'(s_ff);
                  mult_in  = s_ff;
                  iter_in  = ITER_W'(SUM_W);
               end else begin
                  state_in = FIN_DIV_MEAN;
                  rem_in   = '0;
                  quo_in   = DIV_W'({s_ff, 8'd0});
                  iter_in  = ITER_W'(DIV_W);
               end
            end
         end
         FIN_DIV_MEAN, FIN_DIV_A, FIN_DIV_Y: begin
            // restoring division, one quotient bit per cycle
            rem_in  = borrow ? shifted : alu_y[DW-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], !borrow};
            iter_in = iter_ff - ITER_ONE;
            if (iter_ff == ITER_ONE) begin
               case (state_ff)
                  FIN_DIV_MEAN: begin
                     rsp_in.mean_q8 = quo_in[15:0];
                     state_in       = FIN_DIV_A;
                     rem_in         = '0;
                     quo_in         = {acc_ff, 16'd0};
                     iter_in        = ITER_W'(DIV_W);
                  end
                  FIN_DIV_A: begin
                     state_in = FIN_DIV_Y;
                     rem_in   = '0;
                     iter_in  = ITER_W'(DIV_W);
                  end
                  default: begin
                     rsp_in.variance_q8 = quo_in[Y_W-1:8];
                     state_in           = FIN_SQRT;
                     acc_in             = DW'(quo_in[Y_W-1:0]);
                     root_in            = '0;
                     bit_in             = ROOT_W'(1) << (ROOT_W - 2);
                     iter_in            = ITER_W'(ROOT_STEPS);
                  end
               endcase
            end
         end
         FIN_SQRT: begin
            if (!borrow) begin
               acc_in  = alu_y[DW-1:0];
               root_in = (root_ff >> 1) | bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff - ITER_ONE;
            if (iter_ff == ITER_ONE) begin
               rsp_in.std_dev_q8 = root_in[14:0];
               state_in          = FIN_DONE;
            end
         end
         FIN_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = FIN_IDLE;
            end
         end
         default: begin
            state_in = FIN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIN_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      opnd_ff <= opnd_in;
      mult_ff <= mult_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      n_ff    <= n_in;
      s_ff    <= s_in;
      rsp_ff  <= rsp_in;
   end

   assign busy = (state_ff != FIN_IDLE);
   assign rsp  = rsp_ff;

`ifndef SYNTH
   a_iter_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff != FIN_IDLE && state_ff != FIN_DONE) |-> iter_ff != '0)
      else $error("iteration count ran out inside an arithmetic phase");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == FIN_IDLE)
      else $error("frame end taken while finishing previous frame");

   a_root_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == FIN_SQRT |-> $onehot(bit_ff))
      else $error("square root trial bit lost");

   a_y_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FIN_DIV_Y && iter_ff == ITER_ONE) |-> quo_in[DIV_W-1:Y_W] == '0)
      else $error("scaled variance exceeds its range");
`endif

endmodule
`default_nettype wire

[rtl/image_intensity_statistics_top.sv]
// Pixels without the last flag are taken one per cycle while req_stall is low.
// A beat with last starts the divide/root sequencer, which runs the shift-add
// multiplies, three restoring divisions and the root iterations on the one
// shared adder. req_stall is high while the sequencer is busy, including
// any wait for the output register to free up.
// Reset is synchronous: limits return to 85/170, frame totals clear and rsp_valid drops.
`default_nettype none
module image_intensity_statistics_top import iss_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type   cfg;
   stats_type stats;
   rsp_type   fin_rsp;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      busy;
   logic      done;
   logic      out_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   iss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   iss_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .stats  (stats)
   );

   iss_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && req_data.last),
      .stats    (stats),
      .out_free (out_free),
      .busy     (busy),
      .done     (done),
      .rsp      (fin_rsp)
   );

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (done) begin
         rsp_data_in  = fin_rsp;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import iss_pkg::*;

   localparam int RESULT_LATENCY = CNT_W + SUM_W + 3*DIV_W + 17;
   localparam int CFG_SETTLE     = 8;
   localparam int STALL_LIMIT    = 20000;
   localparam longint unsigned COUNT_BOUND = longint'(1) << PIXEL_COUNT_BITS;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // frame totals and limits as the block should hold them
   logic [7:0]      lim_dark = DARK_LIMIT_RESET;
   logic [7:0]      lim_medium = MEDIUM_LIMIT_RESET;
   longint unsigned fr_count, fr_sum, fr_sq, fr_dark, fr_medium, fr_bright;
   logic [7:0]      fr_min, fr_max;
   bit              fr_overflow;

   rsp_type frame_results[$];
   rsp_type want_rsp;
   int      mismatches = 0;

   // sender and receiver pacing
   bit gaps_on = 1'b0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_run = 0;
   bit stall_level = 1'b0;
   int hold_left = 0;

   image_intensity_statistics_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] rem, root, probe;
      rem = v;
      root = '0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic void clear_frame_totals();
      fr_count = 0;
      fr_sum = 0;
      fr_sq = 0;
      fr_dark = 0;
      fr_medium = 0;
      fr_bright = 0;
      fr_min = PIXEL_MAX;
      fr_max = 8'd0;
      fr_overflow = 1'b0;
   endfunction

   function automatic rsp_type frame_summary();
      logic [127:0] n, s, q, d, mean, var_q, dev_sq;
      rsp_type r;
      r = '0;
      n = fr_count;
      s = fr_sum;
      q = fr_sq;
      r.pixel_count  = n[24:0];
      r.min_value    = fr_min;
      r.max_value    = fr_max;
      r.dark_total   = fr_dark[24:0];
      r.medium_total = fr_medium[24:0];
      r.bright_total = fr_bright[24:0];
      r.overflow     = fr_overflow;
      if (n != 0) begin
         d = n * q - s * s;
         mean = (s << 8) / n;
         var_q = ((d << 8) / n) / n;
         dev_sq = ((d << 16) / n) / n;
         r.mean_q8     = mean[15:0];
         r.variance_q8 = var_q[21:0];
         r.std_dev_q8  = 15'(int_sqrt(dev_sq[63:0]));
      end
      return r;
   endfunction

   function automatic void take_pixel(input req_type beat);
      if (fr_count < COUNT_BOUND) begin
         fr_count++;
         if (beat.pixel < fr_min) fr_min = beat.pixel;
         if (beat.pixel > fr_max) fr_max = beat.pixel;
         fr_sum += beat.pixel;
         fr_sq += longint'(beat.pixel) * longint'(beat.pixel);
         if (beat.pixel <= lim_dark) fr_dark++;
         else if (beat.pixel <= lim_medium) fr_medium++;
         else fr_bright++;
      end else begin
         fr_overflow = 1'b1;
      end
      if (beat.last) begin
         frame_results.push_back(frame_summary());
         clear_frame_totals();
      end
   endfunction

   // valid stays high after the accepting edge; the next call or release_bus moves it
   task automatic send_pixel(input logic [7:0] px, input logic lst);
      req_type beat;
      int gap;
      beat.pixel = px;
      beat.last = lst;
      if (gaps_on && burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      take_pixel(beat);
   endtask

   task automatic release_bus();
      req_valid <= 1'b0;
   endtask

   task automatic drain_results();
      release_bus();
      @(posedge clock);
      while (frame_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input csr_reg_type idx, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= {24'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (idx == REG_DARK_LIMIT) lim_dark = value;
      else lim_medium = value;
   endtask

   task automatic set_limits(input logic [7:0] dark, input logic [7:0] medium_lim);
      drain_results();
      repeat (CFG_SETTLE) @(posedge clock);
      write_limit(REG_DARK_LIMIT, dark);
      @(posedge clock);
      write_limit(REG_MEDIUM_LIMIT, medium_lim);
   endtask

   function automatic logic [7:0] pick_pixel(input int mode);
      logic [7:0] base;
      case (mode)
         0: return 8'($urandom_range(0, 255));
         1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         2: begin
            base = $urandom_range(0, 1) ? lim_dark : lim_medium;
            return 8'(int'(base) + int'($urandom_range(0, 2)) - 1);
         end
         default: return 8'($urandom_range(250, 255));
      endcase
   endfunction

   // mostly short frames so the per-frame divide does not dominate the run
   function automatic int frame_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(1, 16);
      else if (roll < 97) return $urandom_range(17, 64);
      else return $urandom_range(65, 400);
   endfunction

   task automatic send_frame(input int len, input int mode);
      for (int i = 0; i < len; i++) send_pixel(pick_pixel(mode), i == len - 1);
   endtask

   task automatic test_directed();
      gaps_on = 1'b0;
      stall_pct = 0;
      // single-pixel frames at both ends
      send_pixel(8'd0, 1'b1);
      send_pixel(8'd255, 1'b1);
      // widest spread
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b1);
      // both sides of each class boundary at the reset limits
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd84, 1'b0);
      send_pixel(8'd85, 1'b0);
      send_pixel(8'd86, 1'b0);
      send_pixel(8'd169, 1'b0);
      send_pixel(8'd170, 1'b0);
      send_pixel(8'd171, 1'b0);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd1, 1'b1);
      // flat frame, zero variance
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd128, 1'b1);
   endtask

   task automatic test_limit_settings();
      logic [7:0] dark, medium_lim;
      gaps_on = 1'b1;
      stall_pct = 30;
      for (int k = 0; k < 7; k++) begin
         case (k)
            0: begin dark = 8'd0;   medium_lim = 8'd0;   end
            1: begin dark = 8'd255; medium_lim = 8'd255; end
            2: begin dark = 8'd0;   medium_lim = 8'd255; end
            3: begin dark = 8'd255; medium_lim = 8'd0;   end
            4: begin dark = 8'd200; medium_lim = 8'd50;  end  // crossed limits
            5: begin dark = 8'd85;  medium_lim = 8'd170; end
            default: begin
               dark = 8'($urandom_range(0, 255));
               medium_lim = 8'($urandom_range(0, 255));
            end
         endcase
         set_limits(dark, medium_lim);
         send_frame($urandom_range(4, 12), 2);
         send_frame($urandom_range(4, 12), 0);
      end
   endtask

   task automatic test_output_hold();
      drain_results();
      gaps_on = 1'b0;
      stall_pct = 0;
      hold_left = 2500;
      for (int i = 0; i < 5; i++) send_frame($urandom_range(2, 10), $urandom_range(0, 3));
   endtask

   task automatic test_random_frames();
      int sent, frames, len;
      sent = 0;
      frames = 0;
      while (sent < 1450) begin
         if (frames % 10 == 9) begin
            case ($urandom_range(0, 4))
               0: set_limits(8'd0, 8'($urandom_range(0, 255)));
               1: set_limits(8'($urandom_range(0, 255)), 8'd255);
               default: set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
         end
         if (frames % 6 == 0) begin
            gaps_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         len = frame_length();
         send_frame(len, $urandom_range(0, 3));
         sent += len;
         frames++;
      end
   endtask

   task automatic test_full_rate();
      gaps_on = 1'b0;
      stall_pct = 0;
      for (int i = 0; i < 8; i++) send_frame($urandom_range(10, 40), 0);
   endtask

   task automatic test_drain_pause();
      gaps_on = 1'b1;
      stall_pct = 40;
      for (int i = 0; i < 3; i++) send_frame($urandom_range(3, 15), $urandom_range(0, 3));
      drain_results();
      for (int i = 0; i < 3; i++) send_frame($urandom_range(3, 15), $urandom_range(0, 3));
   endtask

   // receiver: stall runs of random length, plus an occasional long hold-off
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_run <= 0) begin
            stall_run = $urandom_range(1, 8);
            stall_level = $urandom_range(0, 99) < stall_pct;
         end
         stall_run--;
         rsp_stall <= stall_level;
      end
   end

   task automatic compare_field(input string label, input logic [24:0] want,
                                input logic [24:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("%0t result beat with none expected", $realtime);
         end else begin
            want_rsp = frame_results.pop_front();
            compare_field("pixel_count", want_rsp.pixel_count, rsp_data.pixel_count);
            compare_field("min_value", want_rsp.min_value, rsp_data.min_value);
            compare_field("max_value", want_rsp.max_value, rsp_data.max_value);
            compare_field("mean_q8", want_rsp.mean_q8, rsp_data.mean_q8);
            compare_field("variance_q8", want_rsp.variance_q8, rsp_data.variance_q8);
            compare_field("std_dev_q8", want_rsp.std_dev_q8, rsp_data.std_dev_q8);
            compare_field("dark_total", want_rsp.dark_total, rsp_data.dark_total);
            compare_field("medium_total", want_rsp.medium_total, rsp_data.medium_total);
            compare_field("bright_total", want_rsp.bright_total, rsp_data.bright_total);
            compare_field("overflow", want_rsp.overflow, rsp_data.overflow);
         end
      end
   end

   // ends the run if neither channel nor the register port moves for too long
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      clear_frame_totals();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limit_settings();
      test_output_hold();
      test_random_frames();
      test_full_rate();
      test_drain_pause();
      drain_results();
      repeat (RESULT_LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && frame_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
